// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PNCF_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pncf check failed");

// next-cycle implication, checked outside reset
`define PNCF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pncf check failed");

// next-cycle implication, also checked across reset
`define PNCF_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pncf check failed");

`endif

// ===== hdl/pncf_pkg.sv =====
`timescale 1ns / 1ps

package pncf_pkg;

    localparam int TD_W     = 32;
    localparam int Q1_W     = 64;
    localparam int S1_W     = 32;
    localparam int S2_W     = 28;
    localparam int S3_W     = 26;
    localparam int FRAC_W   = 24;
    localparam int P3_W     = 30;
    localparam int P5_W     = 34;
    localparam int P6_W     = 36;
    localparam int P7_W     = 38;
    localparam int COEF_W   = 32;
    localparam int MAG_W    = 46;
    localparam int SUM_W    = 49;
    localparam int M_W      = 32;
    localparam int FREQ_W   = 32;
    localparam int LOW_W    = 12;
    localparam int ORDER_W  = 3;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TIME  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

    localparam logic [IDX_W-1:0] REG_PN_ORDER   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_TWO   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_THREE = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_FOUR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_EIGHT_PI_M = 3'd4;

    localparam logic [ORDER_W-1:0] ORDER_TWO   = 3'd2;
    localparam logic [ORDER_W-1:0] ORDER_THREE = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_FOUR  = 3'd4;

endpackage

// ===== hdl/pncf_isqrt.sv =====
`timescale 1ns / 1ps

// pipelined restoring square root, one root bit per stage
module pncf_isqrt #(
    parameter int N      = 32,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*N-1:0]    in_x,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [N-1:0]      out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int X_W   = 2 * N;
    localparam int REM_W = N + 2;

    logic              vld_reg  [1:N];
    logic [REM_W-1:0]  rem_reg  [1:N-1];
    logic [X_W-1:0]    x_reg    [1:N-1];
    logic [N-1:0]      root_reg [1:N];
    logic [SIDE_W-1:0] side_reg [1:N];

    for (genvar k = 1; k <= N; k++) begin : g_stage
        logic              vld_in;
        logic [REM_W-1:0]  rem_in;
        logic [X_W-1:0]    x_in;
        logic [N-1:0]      root_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W+1:0]  cat;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 1) begin : g_head
            assign vld_in  = in_valid;
            assign rem_in  = '0;
            assign x_in    = in_x;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_body
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign cat   = {rem_in, x_in[X_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cat >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_in[N-2:0], ge};
                side_reg[k] <= side_in;
            end
        end

        if (k < N) begin : g_carry
            logic [REM_W-1:0] rem_next;
            assign rem_next = ge ? REM_W'(cat - trial) : cat[REM_W-1:0];
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    x_reg[k]   <= {x_in[X_W-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

// ===== hdl/pn_chirp_frequency_from_time.sv =====
`timescale 1ns / 1ps

// Post-Newtonian chirp frequency: for each time-to-coalescence sample td (unsigned
// Q16.16) the block returns f = (td^-3/8 + a2*td^-5/8 - a3*td^-3/4 + a4*td^-7/8)
// / eight_pi_mass as unsigned Q20.12, with status 0 ok, 1 zero time, 2 saturated.
// A sample is taken every cycle while the result side does not stall. The pipeline
// is a 64-stage reciprocal divider, three square-root pipelines of 32, 28 and 26
// stages, seven multiply, sum and setup stages, a 32-stage quotient divider and
// the output register; the dividers and square roots give one bit per stage.
// A stall on the result side freezes the whole pipeline. Configuration registers
// are read live by the stages and must only be written while the block is empty.
module pn_chirp_frequency_from_time (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pncf_pkg::IDX_W-1:0]          cfg_index,
    input  logic [31:0]                         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pncf_pkg::TD_W-1:0]           s_time_to_merge,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pncf_pkg::FREQ_W-1:0]         m_frequency,
    output logic [pncf_pkg::STATUS_W-1:0]       m_result_status
);

    import pncf_pkg::*;

    localparam int D1_STEPS = Q1_W;
    localparam int D2_STEPS = FREQ_W;

    // configuration registers
    logic [ORDER_W-1:0] pn_order_reg;
    logic [COEF_W-1:0]  coef_two_reg;
    logic [COEF_W-1:0]  coef_three_reg;
    logic [COEF_W-1:0]  coef_four_reg;
    logic [M_W-1:0]     eight_pi_mass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_order_reg      <= ORDER_FOUR;
            coef_two_reg      <= '0;
            coef_three_reg    <= '0;
            coef_four_reg     <= '0;
            eight_pi_mass_reg <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PN_ORDER:   pn_order_reg      <= cfg_wdata[ORDER_W-1:0];
                REG_COEF_TWO:   coef_two_reg      <= cfg_wdata[COEF_W-1:0];
                REG_COEF_THREE: coef_three_reg    <= cfg_wdata[COEF_W-1:0];
                REG_COEF_FOUR:  coef_four_reg     <= cfg_wdata[COEF_W-1:0];
                REG_EIGHT_PI_M: eight_pi_mass_reg <= cfg_wdata[M_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the output holds an untaken transfer
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------
    // reciprocal: v = floor((2^64 - 1) / td), one quotient bit per stage
    // ---------------------------------------------------------------
    logic             d1_vld_reg [1:D1_STEPS];
    logic [TD_W-1:0]  d1_rem_reg [1:D1_STEPS-1];
    logic [TD_W-1:0]  d1_td_reg  [1:D1_STEPS];
    logic [Q1_W-1:0]  d1_quo_reg [1:D1_STEPS];

    for (genvar k = 1; k <= D1_STEPS; k++) begin : g_div1
        logic            vld_in;
        logic [TD_W-1:0] rem_in;
        logic [TD_W-1:0] td_in;
        logic [Q1_W-1:0] quo_in;
        logic [TD_W:0]   trial;
        logic            ge;

        if (k == 1) begin : g_head
            assign vld_in = s_valid;
            assign rem_in = '0;
            assign td_in  = s_time_to_merge;
            assign quo_in = '0;
        end else begin : g_body
            assign vld_in = d1_vld_reg[k-1];
            assign rem_in = d1_rem_reg[k-1];
            assign td_in  = d1_td_reg[k-1];
            assign quo_in = d1_quo_reg[k-1];
        end

        // dividend is all ones, so every step shifts in a one
        assign trial = {rem_in, 1'b1};
        assign ge    = (trial >= {1'b0, td_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d1_vld_reg[k] <= 1'b0;
            end else if (en) begin
                d1_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d1_td_reg[k]  <= td_in;
                d1_quo_reg[k] <= {quo_in[Q1_W-2:0], ge};
            end
        end

        if (k < D1_STEPS) begin : g_carry
            logic [TD_W-1:0] rem_next;
            assign rem_next = ge ? TD_W'(trial - {1'b0, td_in}) : trial[TD_W-1:0];
            always_ff @(posedge aclk) begin
                if (en) begin
                    d1_rem_reg[k] <= rem_next;
                end
            end
        end
    end

    logic d1_zero;
    assign d1_zero = (d1_td_reg[D1_STEPS] == '0);

    // ---------------------------------------------------------------
    // s1 = td^-1/2, s2 = td^-1/4, s3 = td^-1/8, all Q.24
    // ---------------------------------------------------------------
    logic            sq1_vld;
    logic [S1_W-1:0] sq1_root;
    logic            sq1_zero;

    pncf_isqrt #(.N(S1_W), .SIDE_W(1)) u_sqrt1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d1_vld_reg[D1_STEPS]),
        .in_x      (d1_quo_reg[D1_STEPS]),
        .in_side   (d1_zero),
        .out_valid (sq1_vld),
        .out_root  (sq1_root),
        .out_side  (sq1_zero)
    );

    logic            sq2_vld;
    logic [S2_W-1:0] sq2_root;
    logic [S1_W:0]   sq2_side;

    pncf_isqrt #(.N(S2_W), .SIDE_W(S1_W + 1)) u_sqrt2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq1_vld),
        .in_x      ({sq1_root, {FRAC_W{1'b0}}}),
        .in_side   ({sq1_zero, sq1_root}),
        .out_valid (sq2_vld),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );

    logic                 sq3_vld;
    logic [S3_W-1:0]      sq3_root;
    logic [S1_W+S2_W:0]   sq3_side;

    pncf_isqrt #(.N(S3_W), .SIDE_W(S1_W + S2_W + 1)) u_sqrt3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq2_vld),
        .in_x      ({sq2_root, {FRAC_W{1'b0}}}),
        .in_side   ({sq2_side, sq2_root}),
        .out_valid (sq3_vld),
        .out_root  (sq3_root),
        .out_side  (sq3_side)
    );

    logic            sq3_zero;
    logic [S1_W-1:0] s1;
    logic [S2_W-1:0] s2;
    assign sq3_zero = sq3_side[S1_W+S2_W];
    assign s1       = sq3_side[S1_W+S2_W-1:S2_W];
    assign s2       = sq3_side[S2_W-1:0];

    // ---------------------------------------------------------------
    // stage p1: p3, p5, p6
    // ---------------------------------------------------------------
    logic [S3_W+S2_W-1:0] prod_32;
    logic [S1_W+S3_W-1:0] prod_15;
    logic [S1_W+S2_W-1:0] prod_16;
    assign prod_32 = sq3_root * s2;
    assign prod_15 = s1 * sq3_root;
    assign prod_16 = s1 * s2;

    logic            p1_vld_reg;
    logic            p1_zero_reg;
    logic [P3_W-1:0] p1_p3_reg;
    logic [P5_W-1:0] p1_p5_reg;
    logic [P6_W-1:0] p1_p6_reg;
    logic [S3_W-1:0] p1_s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= sq3_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_zero_reg <= sq3_zero;
            p1_p3_reg   <= prod_32[S3_W+S2_W-1:FRAC_W];
            p1_p5_reg   <= prod_15[S1_W+S3_W-1:FRAC_W];
            p1_p6_reg   <= prod_16[S1_W+S2_W-1:FRAC_W];
            p1_s3_reg   <= sq3_root;
        end
    end

    // ---------------------------------------------------------------
    // stage p2: p6 * s3 split into a 32-bit and a 4-bit partial product
    // ---------------------------------------------------------------
    localparam int P6_LO_W = 32;
    localparam int P6_HI_W = P6_W - P6_LO_W;

    logic [P6_LO_W+S3_W-1:0] p7_lo;
    logic [P6_HI_W+S3_W-1:0] p7_hi;
    assign p7_lo = p1_p6_reg[P6_LO_W-1:0] * p1_s3_reg;
    assign p7_hi = p1_p6_reg[P6_W-1:P6_LO_W] * p1_s3_reg;

    logic                    p2_vld_reg;
    logic                    p2_zero_reg;
    logic [P3_W-1:0]         p2_p3_reg;
    logic [P5_W-1:0]         p2_p5_reg;
    logic [P6_W-1:0]         p2_p6_reg;
    logic [P6_LO_W+S3_W-1:0] p2_p7_lo_reg;
    logic [P6_HI_W+S3_W-1:0] p2_p7_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_zero_reg  <= p1_zero_reg;
            p2_p3_reg    <= p1_p3_reg;
            p2_p5_reg    <= p1_p5_reg;
            p2_p6_reg    <= p1_p6_reg;
            p2_p7_lo_reg <= p7_lo;
            p2_p7_hi_reg <= p7_hi;
        end
    end

    // ---------------------------------------------------------------
    // stage p3: join the partial products into p7
    // ---------------------------------------------------------------
    logic [P6_W+S3_W-1:0] p7_full;
    assign p7_full = {p2_p7_hi_reg, {P6_LO_W{1'b0}}}
                   + (P6_W + S3_W)'(p2_p7_lo_reg);

    logic            p3_vld_reg;
    logic            p3_zero_reg;
    logic [P3_W-1:0] p3_p3_reg;
    logic [P5_W-1:0] p3_p5_reg;
    logic [P6_W-1:0] p3_p6_reg;
    logic [P7_W-1:0] p3_p7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (en) begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_zero_reg <= p2_zero_reg;
            p3_p3_reg   <= p2_p3_reg;
            p3_p5_reg   <= p2_p5_reg;
            p3_p6_reg   <= p2_p6_reg;
            p3_p7_reg   <= p7_full[P6_W+S3_W-1:FRAC_W];
        end
    end

    // ---------------------------------------------------------------
    // stage p4: |a| times integer and fraction parts of each power
    // ---------------------------------------------------------------
    logic [COEF_W-1:0] mag_two;
    logic [COEF_W-1:0] mag_three;
    logic [COEF_W-1:0] mag_four;
    // negating the most negative code still gives the right unsigned magnitude
    assign mag_two   = coef_two_reg[COEF_W-1]   ? -coef_two_reg   : coef_two_reg;
    assign mag_three = coef_three_reg[COEF_W-1] ? -coef_three_reg : coef_three_reg;
    assign mag_four  = coef_four_reg[COEF_W-1]  ? -coef_four_reg  : coef_four_reg;

    localparam int HI2_W = COEF_W + P5_W - FRAC_W;
    localparam int HI3_W = COEF_W + P6_W - FRAC_W;
    localparam int HI4_W = COEF_W + P7_W - FRAC_W;
    localparam int LO_W  = COEF_W + FRAC_W;

    logic [HI2_W-1:0] hi_two;
    logic [HI3_W-1:0] hi_three;
    logic [HI4_W-1:0] hi_four;
    logic [LO_W-1:0]  lo_two;
    logic [LO_W-1:0]  lo_three;
    logic [LO_W-1:0]  lo_four;
    assign hi_two   = mag_two   * p3_p5_reg[P5_W-1:FRAC_W];
    assign hi_three = mag_three * p3_p6_reg[P6_W-1:FRAC_W];
    assign hi_four  = mag_four  * p3_p7_reg[P7_W-1:FRAC_W];
    assign lo_two   = mag_two   * p3_p5_reg[FRAC_W-1:0];
    assign lo_three = mag_three * p3_p6_reg[FRAC_W-1:0];
    assign lo_four  = mag_four  * p3_p7_reg[FRAC_W-1:0];

    logic             p4_vld_reg;
    logic             p4_zero_reg;
    logic [P3_W-1:0]  p4_p3_reg;
    logic [HI2_W-1:0] p4_hi_two_reg;
    logic [HI3_W-1:0] p4_hi_three_reg;
    logic [HI4_W-1:0] p4_hi_four_reg;
    logic [LO_W-1:0]  p4_lo_two_reg;
    logic [LO_W-1:0]  p4_lo_three_reg;
    logic [LO_W-1:0]  p4_lo_four_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_vld_reg <= 1'b0;
        end else if (en) begin
            p4_vld_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_zero_reg     <= p3_zero_reg;
            p4_p3_reg       <= p3_p3_reg;
            p4_hi_two_reg   <= hi_two;
            p4_hi_three_reg <= hi_three;
            p4_hi_four_reg  <= hi_four;
            p4_lo_two_reg   <= lo_two;
            p4_lo_three_reg <= lo_three;
            p4_lo_four_reg  <= lo_four;
        end
    end

    // ---------------------------------------------------------------
    // stage p5: truncated magnitudes, signed and gated by order
    // ---------------------------------------------------------------
    logic [MAG_W-1:0] t_two;
    logic [MAG_W-1:0] t_three;
    logic [MAG_W-1:0] t_four;
    assign t_two   = MAG_W'(p4_hi_two_reg)   + MAG_W'(p4_lo_two_reg[LO_W-1:FRAC_W]);
    assign t_three = MAG_W'(p4_hi_three_reg) + MAG_W'(p4_lo_three_reg[LO_W-1:FRAC_W]);
    assign t_four  = p4_hi_four_reg          + MAG_W'(p4_lo_four_reg[LO_W-1:FRAC_W]);

    logic use_two;
    logic use_three;
    logic use_four;
    // orders above four behave as four
    assign use_two   = (pn_order_reg >= ORDER_TWO);
    assign use_three = (pn_order_reg >= ORDER_THREE);
    assign use_four  = (pn_order_reg >= ORDER_FOUR);

    logic [SUM_W-1:0] st_two_next;
    logic [SUM_W-1:0] st_three_next;
    logic [SUM_W-1:0] st_four_next;

    always_comb begin
        st_two_next   = '0;
        st_three_next = '0;
        st_four_next  = '0;
        if (use_two) begin
            st_two_next = coef_two_reg[COEF_W-1] ? -SUM_W'(t_two) : SUM_W'(t_two);
        end
        if (use_three) begin
            st_three_next = coef_three_reg[COEF_W-1] ? -SUM_W'(t_three) : SUM_W'(t_three);
        end
        if (use_four) begin
            st_four_next = coef_four_reg[COEF_W-1] ? -SUM_W'(t_four) : SUM_W'(t_four);
        end
    end

    logic             p5_vld_reg;
    logic             p5_zero_reg;
    logic [P3_W-1:0]  p5_p3_reg;
    logic [SUM_W-1:0] st_two_reg;
    logic [SUM_W-1:0] st_three_reg;
    logic [SUM_W-1:0] st_four_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_vld_reg <= 1'b0;
        end else if (en) begin
            p5_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_zero_reg  <= p4_zero_reg;
            p5_p3_reg    <= p4_p3_reg;
            st_two_reg   <= st_two_next;
            st_three_reg <= st_three_next;
            st_four_reg  <= st_four_next;
        end
    end

    // ---------------------------------------------------------------
    // stage p6: signed Q.24 sum, two's complement in SUM_W bits
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] acc_next;
    assign acc_next = SUM_W'(p5_p3_reg) + st_two_reg - st_three_reg + st_four_reg;

    logic             p6_vld_reg;
    logic             p6_zero_reg;
    logic [SUM_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p6_vld_reg <= 1'b0;
        end else if (en) begin
            p6_vld_reg <= p5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p6_zero_reg <= p5_zero_reg;
            acc_reg     <= acc_next;
        end
    end

    // ---------------------------------------------------------------
    // stage p7: special cases and setup of the final divider
    // ---------------------------------------------------------------
    logic [SUM_W-2:0]    sum_mag;
    logic [M_W+LOW_W-1:0] limit;
    logic                acc_neg;
    logic                acc_nil;
    logic                acc_sat;
    assign sum_mag = acc_reg[SUM_W-2:0];
    assign limit   = {eight_pi_mass_reg, {LOW_W{1'b0}}};
    assign acc_neg = acc_reg[SUM_W-1];
    assign acc_nil = (acc_reg == '0);
    assign acc_sat = (sum_mag >= (SUM_W - 1)'(limit));

    logic                force_next;
    logic [FREQ_W-1:0]   fval_next;
    logic [STATUS_W-1:0] status_next;

    always_comb begin
        force_next  = 1'b1;
        fval_next   = '0;
        status_next = STATUS_OK;
        if (p6_zero_reg) begin
            status_next = STATUS_BAD_TIME;
        end else if (acc_nil) begin
            status_next = STATUS_OK;
        end else if (acc_neg) begin
            status_next = STATUS_SATURATED;
        end else if (acc_sat) begin
            fval_next   = '1;
            status_next = STATUS_SATURATED;
        end else begin
            force_next = 1'b0;
        end
    end

    logic                p7_vld_reg;
    logic                p7_force_reg;
    logic [FREQ_W-1:0]   p7_fval_reg;
    logic [STATUS_W-1:0] p7_status_reg;
    logic [M_W-1:0]      p7_rem_reg;
    logic [LOW_W-1:0]    p7_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p7_vld_reg <= 1'b0;
        end else if (en) begin
            p7_vld_reg <= p6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p7_force_reg  <= force_next;
            p7_fval_reg   <= fval_next;
            p7_status_reg <= status_next;
            // below the limit, sum >> 12 is already less than the divisor
            p7_rem_reg    <= sum_mag[M_W+LOW_W-1:LOW_W];
            p7_low_reg    <= sum_mag[LOW_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // quotient: floor(sum * 2^20 / m), one bit per stage
    // ---------------------------------------------------------------
    logic                d2_vld_reg    [1:D2_STEPS];
    logic [M_W-1:0]      d2_rem_reg    [1:D2_STEPS-1];
    logic [LOW_W-1:0]    d2_low_reg    [1:D2_STEPS-1];
    logic [FREQ_W-1:0]   d2_quo_reg    [1:D2_STEPS];
    logic                d2_force_reg  [1:D2_STEPS];
    logic [FREQ_W-1:0]   d2_fval_reg   [1:D2_STEPS];
    logic [STATUS_W-1:0] d2_status_reg [1:D2_STEPS];

    for (genvar k = 1; k <= D2_STEPS; k++) begin : g_div2
        logic                vld_in;
        logic [M_W-1:0]      rem_in;
        logic [LOW_W-1:0]    low_in;
        logic [FREQ_W-1:0]   quo_in;
        logic                force_in;
        logic [FREQ_W-1:0]   fval_in;
        logic [STATUS_W-1:0] status_in;
        logic [M_W:0]        trial;
        logic                ge;

        if (k == 1) begin : g_head
            assign vld_in    = p7_vld_reg;
            assign rem_in    = p7_rem_reg;
            assign low_in    = p7_low_reg;
            assign quo_in    = '0;
            assign force_in  = p7_force_reg;
            assign fval_in   = p7_fval_reg;
            assign status_in = p7_status_reg;
        end else begin : g_body
            assign vld_in    = d2_vld_reg[k-1];
            assign rem_in    = d2_rem_reg[k-1];
            assign low_in    = d2_low_reg[k-1];
            assign quo_in    = d2_quo_reg[k-1];
            assign force_in  = d2_force_reg[k-1];
            assign fval_in   = d2_fval_reg[k-1];
            assign status_in = d2_status_reg[k-1];
        end

        // low sum bits come in first, then the zeros of the 2^20 scale
        assign trial = {rem_in, low_in[LOW_W-1]};
        assign ge    = (trial >= {1'b0, eight_pi_mass_reg});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d2_vld_reg[k] <= 1'b0;
            end else if (en) begin
                d2_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d2_quo_reg[k]    <= {quo_in[FREQ_W-2:0], ge};
                d2_force_reg[k]  <= force_in;
                d2_fval_reg[k]   <= fval_in;
                d2_status_reg[k] <= status_in;
            end
        end

        if (k < D2_STEPS) begin : g_carry
            logic [M_W-1:0] rem_next;
            assign rem_next = ge ? M_W'(trial - {1'b0, eight_pi_mass_reg}) : trial[M_W-1:0];
            always_ff @(posedge aclk) begin
                if (en) begin
                    d2_rem_reg[k] <= rem_next;
                    d2_low_reg[k] <= {low_in[LOW_W-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [FREQ_W-1:0]   freq_reg;
    logic [STATUS_W-1:0] status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d2_vld_reg[D2_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            freq_reg   <= d2_force_reg[D2_STEPS] ? d2_fval_reg[D2_STEPS]
                                                 : d2_quo_reg[D2_STEPS];
            status_reg <= d2_status_reg[D2_STEPS];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frequency     = freq_reg;
    assign m_result_status = status_reg;

endmodule

// ===== hdl/pncf_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pncf_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [pncf_pkg::FREQ_W-1:0]         m_frequency,
    input logic [pncf_pkg::STATUS_W-1:0]       m_result_status
);

    import pncf_pkg::*;

    // zero time always reports a zero frequency
    `PNCF_ASSERT_NOW(a_bad_time_zero, aclk, aresetn,
        m_valid && (m_result_status == STATUS_BAD_TIME), m_frequency == '0)

    // saturation pins the frequency to one of its rails
    `PNCF_ASSERT_NOW(a_sat_rail, aclk, aresetn,
        m_valid && (m_result_status == STATUS_SATURATED),
        (m_frequency == '0) || (m_frequency == '1))

    // a stalled result transfer holds
    `PNCF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_frequency) && $stable(m_result_status))

    // reset empties the pipeline
    `PNCF_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind pn_chirp_frequency_from_time pncf_checker u_pncf_checker (.*);

// ===== tb/tb_pn_chirp_frequency_from_time.sv =====
`timescale 1ns / 1ps

module tb_pn_chirp_frequency_from_time;
    import pncf_pkg::*;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [STATUS_W-1:0] status;
    } chirp_result_t;

    localparam int PIPE_LAT  = 190;
    localparam int HOLD_CYCS = 600;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TD_W-1:0]      s_time_to_merge = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [FREQ_W-1:0]    m_frequency;
    logic [STATUS_W-1:0]  m_result_status;

    // local copy of the register file
    logic [2:0]  cur_order = 3'd4;
    logic [31:0] cur_a2 = '0, cur_a3 = '0, cur_a4 = '0;
    logic [31:0] cur_mass = 32'hFFFF_FFFF;

    logic [TD_W-1:0] pending_times[$];
    chirp_result_t   expected_freqs[$];
    int  error_count = 0;
    bit  feeding = 1'b0;
    bit  hold_off = 1'b0;
    bit  hold_req = 1'b0;
    bit  in_taken = 1'b0;

    pn_chirp_frequency_from_time dut (.*);

    always #10 aclk = ~aclk;

    initial begin
        #400_000_000;
        $display("[pn_chirp_frequency_from_time] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // bitwise integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // signed Q8.24 coefficient times unsigned Q.24 power, truncated toward zero
    function automatic longint scaled_term(input logic [31:0] coef, input logic [63:0] pw);
        longint c;
        logic [63:0] mag, prod;
        c = longint'(signed'(coef));
        mag = (c < 0) ? 64'(-c) : 64'(c);
        prod = mag * (pw >> FRAC_W) + ((mag * (pw & 64'hFF_FFFF)) >> FRAC_W);
        return (c < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic chirp_result_t chirp_frequency(input logic [31:0] td);
        chirp_result_t res;
        logic [63:0] recip, r1, r2, r3, pw3, pw5, pw6, pw7, lim;
        logic [2:0] ord;
        longint acc;
        ord = (cur_order > 3'd4) ? 3'd4 : cur_order;
        if (td == 0) begin
            res.freq = 0;
            res.status = STATUS_BAD_TIME;
            return res;
        end
        recip = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, td};
        r1 = int_sqrt(recip);
        r2 = int_sqrt(r1 << FRAC_W);
        r3 = int_sqrt(r2 << FRAC_W);
        pw3 = (r3 * r2) >> FRAC_W;
        pw5 = (r1 * r3) >> FRAC_W;
        pw6 = (r1 * r2) >> FRAC_W;
        pw7 = (pw6 * r3) >> FRAC_W;
        acc = longint'(pw3);
        if (ord >= ORDER_TWO) acc += scaled_term(cur_a2, pw5);
        if (ord >= ORDER_THREE) acc -= scaled_term(cur_a3, pw6);
        if (ord >= ORDER_FOUR) acc += scaled_term(cur_a4, pw7);
        lim = {32'd0, cur_mass} << 12;
        if (acc == 0) begin
            res.freq = 0;
            res.status = STATUS_OK;
        end else if (acc < 0) begin
            res.freq = 0;
            res.status = STATUS_SATURATED;
        end else if (64'(acc) >= lim) begin
            res.freq = 32'hFFFF_FFFF;
            res.status = STATUS_SATURATED;
        end else begin
            res.freq = 32'((64'(acc) << 20) / {32'd0, cur_mass});
            res.status = STATUS_OK;
        end
        return res;
    endfunction

    // input transfers are seen at the rising edge and predicted there
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_freqs.push_back(chirp_frequency(s_time_to_merge));
        end
    end

    // driver: bursts of transfers with random gaps
    int gap_left = 0, burst_left = 0;
    always @(negedge aclk) begin
        if (s_valid && !in_taken) begin
            // hold payload until the transfer happens
        end else if (feeding && pending_times.size() > 0 && gap_left == 0) begin
            s_valid <= 1'b1;
            s_time_to_merge <= pending_times.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
                burst_left--;
            end
        end else begin
            s_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end
    end

    // long receiver hold-off, counted here in cycles
    int hold_count = 0;
    always @(negedge aclk) begin
        if (hold_req && !hold_off) begin
            hold_off = 1'b1;
            hold_count = 0;
        end else if (hold_off) begin
            hold_count++;
            if (hold_count >= HOLD_CYCS) hold_off = 1'b0;
        end
    end

    // receiver stall pattern; long hold-off overrides it
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase = (stall_phase + 1) % 64;
        if (hold_off) m_ready <= 1'b0;
        else if (stall_phase < 16) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor: checks each result transfer against the oldest prediction
    always @(posedge aclk) begin
        chirp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_freqs.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_freqs.pop_front();
                if (m_frequency !== want.freq)
                    report_mismatch($sformatf("frequency %h want %h", m_frequency, want.freq));
                if (m_result_status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d",
                        m_result_status, want.status));
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PN_ORDER:   cur_order = val[2:0];
            REG_COEF_TWO:   cur_a2 = val;
            REG_COEF_THREE: cur_a3 = val;
            REG_COEF_FOUR:  cur_a4 = val;
            REG_EIGHT_PI_M: cur_mass = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [2:0] ord, input logic [31:0] a2, input logic [31:0] a3,
                            input logic [31:0] a4, input logic [31:0] mass);
        write_reg(REG_PN_ORDER, {29'd0, ord});
        write_reg(REG_COEF_TWO, a2);
        write_reg(REG_COEF_THREE, a3);
        write_reg(REG_COEF_FOUR, a4);
        write_reg(REG_EIGHT_PI_M, mass);
    endtask

    // random time with a spread of magnitudes
    function automatic logic [31:0] rand_time();
        int sh;
        sh = $urandom_range(0, 31);
        return ($urandom_range(0, 9) == 0) ? $urandom : ($urandom >> sh);
    endfunction

    // push items, wait for every result, then let the pipeline drain
    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++) pending_times.push_back(rand_time());
        feeding = 1'b1;
        wait (pending_times.size() == 0 && !s_valid);
        feeding = 1'b0;
        wait (expected_freqs.size() == 0);
        repeat (PIPE_LAT + 10) @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes of time at reset settings, zero time, all bits
        pending_times.push_back(32'd0);
        pending_times.push_back(32'd1);
        pending_times.push_back(32'hFFFF_FFFF);
        pending_times.push_back(32'h0001_0000);
        pending_times.push_back(32'hAAAA_AAAA);
        pending_times.push_back(32'h5555_5555);
        pending_times.push_back(32'h8000_0000);
        feeding = 1'b1;
        wait (pending_times.size() == 0 && !s_valid);
        feeding = 1'b0;
        wait (expected_freqs.size() == 0);
        repeat (PIPE_LAT + 10) @(negedge aclk);

        // negative sum, zero divisor, small divisor, order above four
        set_regs(3'd2, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 4; i++) pending_times.push_back(32'h0001_0000 << i);
        pending_times.push_back(32'd1);
        run_phase(2);
        set_regs(3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        pending_times.push_back(32'hFFFF_FFFF);
        run_phase(3);
        // sum exactly zero: a3 = 1.0 cancels the leading term at td = 1.0
        set_regs(3'd3, 32'd0, 32'h0100_0000, 32'd0, 32'hFFFF_FFFF);
        pending_times.push_back(32'h0001_0000);
        run_phase(2);
        set_regs(3'd0, $urandom, $urandom, $urandom, 32'h8000_0000);
        run_phase(4);
        set_regs(3'd1, $urandom, $urandom, $urandom, $urandom);
        run_phase(4);

        // long receiver hold-off with the sender still offering, deeper than the pipeline
        for (int i = 0; i < 300; i++) pending_times.push_back(rand_time());
        hold_req = 1'b1;
        wait (hold_off);
        hold_req = 1'b0;
        feeding = 1'b1;
        wait (!hold_off);
        run_phase(0);

        // random phases with assorted settings, modest coefficients mostly
        for (int ph = 0; ph < 7; ph++) begin
            set_regs($urandom_range(0, 7),
                     ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >>> 6),
                     ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >>> 6),
                     ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >>> 6),
                     ($urandom_range(0, 3) == 0) ? $urandom : ($urandom | 32'h0100_0000));
            run_phase(70);
        end

        if (error_count == 0 && expected_freqs.size() == 0)
            $display("[pn_chirp_frequency_from_time] OK");
        else
            $display("[pn_chirp_frequency_from_time] ERROR");
        $finish;
    end

endmodule
